>>> hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

>>> hw/rtl/ecr_pkg.sv
// shared constants, types and helpers for the epsilon closure block
`timescale 1ns / 1ps

package ecr_pkg;

   localparam int ROW_WIDTH = 16;
   localparam int IDX_WIDTH = 4;
   localparam int CNT_WIDTH = 5;
   localparam int MAX_NODES_DEFAULT = 16;
   localparam logic [CNT_WIDTH-1:0] STATE_COUNT_RESET = 5'd16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic                 en;
      logic [IDX_WIDTH-1:0] idx;
      logic [ROW_WIDTH-1:0] row;
   } ecr_wr_type;

   function automatic logic [IDX_WIDTH-1:0] lowest_set(input logic [ROW_WIDTH-1:0] m);
      logic [IDX_WIDTH-1:0] sel;
      sel = '0;
      for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
         if (m[i]) begin
            sel = IDX_WIDTH'(i);
         end
      end
      return sel;
   endfunction

endpackage

>>> hw/rtl/epsilon_closure_reachability_top.sv
// Epsilon closure top level: worklist walk over the adjacency row memory.
// Load beat: taken while idle, no result; the next beat may follow at once.
// Query beat: for each state in the closure a memory read, then a merge, then the result
// register; the next beat is taken once the result is registered, later while an older
// result is stalled. Bad query: no walk, straight to the result register.
// Sync reset clears row valid bits, count to 16, output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epsilon_closure_reachability_top
   import ecr_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [IDX_WIDTH-1:0] req_state_index,
   input  logic [ROW_WIDTH-1:0] req_row_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ROW_WIDTH-1:0] rsp_closure_mask,
   output logic                 rsp_bad_index,
   input  logic                 csr_wr_en,
   input  logic [CNT_WIDTH-1:0] csr_wr_data
);

   localparam int DEPTH = (MAX_NODES < ROW_WIDTH) ? MAX_NODES : ROW_WIDTH;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [ROW_WIDTH-1:0] found_ff, found_in;
   logic [ROW_WIDTH-1:0] pending_ff, pending_in;
   logic                 bad_ff, bad_in;
   logic [CNT_WIDTH-1:0] count_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_WIDTH-1:0] rsp_mask_ff, rsp_mask_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   logic [CNT_WIDTH-1:0] live_n;
   logic [ROW_WIDTH-1:0] keep;
   logic                 req_take;
   logic                 slot_free;
   logic [IDX_WIDTH-1:0] rd_idx;
   logic [ROW_WIDTH-1:0] rd_row;
   logic [ROW_WIDTH-1:0] fresh;
   ecr_wr_type           wr;

   assign live_n = (count_ff > CNT_WIDTH'(DEPTH)) ? CNT_WIDTH'(DEPTH) : count_ff;

   always_comb begin
      for (int j = 0; j < ROW_WIDTH; j++) begin
         keep[j] = CNT_WIDTH'(j) < live_n;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign wr.en  = req_take && (req_opcode == OP_LOAD);
   assign wr.idx = req_state_index;
   assign wr.row = req_row_bits;

   assign rd_idx = lowest_set(pending_ff);
   assign fresh  = rd_row & keep & ~found_ff;

   ecr_row_store #(
      .MAX_NODES (MAX_NODES)
   ) u_rows (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (rd_idx),
      .rd_row (rd_row)
   );

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      pending_in   = pending_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mask_in  = rsp_mask_ff;
      rsp_bad_in   = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_opcode == OP_QUERY)) begin
               if ({1'b0, req_state_index} >= live_n) begin
                  found_in   = '0;
                  pending_in = '0;
                  bad_in     = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  found_in   = ROW_WIDTH'(1) << req_state_index;
                  pending_in = ROW_WIDTH'(1) << req_state_index;
                  bad_in     = 1'b0;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            pending_in = pending_ff & ~(ROW_WIDTH'(1) << rd_idx);
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            found_in   = found_ff | fresh;
            pending_in = pending_ff | fresh;
            state_in   = ((pending_ff | fresh) != '0) ? ST_READ : ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = found_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= '0;
         pending_ff   <= '0;
         bad_ff       <= 1'b0;
         count_ff     <= STATE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_mask_ff  <= '0;
         rsp_bad_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         pending_ff   <= pending_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_mask_ff  <= rsp_mask_in;
         rsp_bad_ff   <= rsp_bad_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_closure_mask = rsp_mask_ff;
   assign rsp_bad_index    = rsp_bad_ff;

   `ASSERT_NEVER(a_pending_in_found, clock, reset,
                 (pending_ff & ~found_ff) != '0, "pending state not in closure")
   `ASSERT_CLK(a_found_in_range, clock, reset,
               (state_ff != ST_IDLE) |-> ((found_ff & ~keep) == '0),
               "closure beyond state count")
   `ASSERT_CLK(a_merge_after_read, clock, reset,
               (state_ff == ST_MERGE) |-> ($past(state_ff) == ST_READ),
               "merge without row read")
   `ASSERT_CLK(a_rsp_from_done, clock, reset,
               $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE),
               "result beat without finished query")
   `ASSERT_CLK(a_bad_is_empty, clock, reset,
               (rsp_valid_ff && rsp_bad_ff) |-> (rsp_mask_ff == '0),
               "bad query with nonempty mask")

endmodule

>>> hw/rtl/ecr_row_store.sv
// adjacency row memory with per-entry valid bits and registered read
`timescale 1ns / 1ps

module ecr_row_store
   import ecr_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ecr_wr_type           wr,
   input  logic [IDX_WIDTH-1:0] rd_idx,
   output logic [ROW_WIDTH-1:0] rd_row
);

   localparam int DEPTH = (MAX_NODES < ROW_WIDTH) ? MAX_NODES : ROW_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   logic [ROW_WIDTH-1:0] rows_ff [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [ROW_WIDTH-1:0] rd_row_ff;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic                 wr_hit;

   assign wr_addr = wr.idx[AW-1:0];
   assign rd_addr = rd_idx[AW-1:0];
   assign wr_hit  = wr.en && ({1'b0, wr.idx} < CNT_WIDTH'(DEPTH));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         rows_ff[wr_addr] <= wr.row;
      end
      rd_row_ff <= valid_ff[rd_addr] ? rows_ff[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_hit) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_row = rd_row_ff;

endmodule

>>> test/tb.sv
// testbench for the epsilon closure block: directed and random nfa graphs checked against a closure predictor
`timescale 1ns / 1ps

module tb;
   import ecr_pkg::*;

   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_SHOWN     = 10;
   localparam int NODE_LIMIT    = MAX_NODES_DEFAULT;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] mask;
      logic                 bad;
   } closure_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_LOAD;
   logic [IDX_WIDTH-1:0] req_state_index = '0;
   logic [ROW_WIDTH-1:0] req_row_bits = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ROW_WIDTH-1:0] rsp_closure_mask;
   logic                 rsp_bad_index;
   logic                 csr_wr_en = 1'b0;
   logic [CNT_WIDTH-1:0] csr_wr_data = '0;

   logic [ROW_WIDTH-1:0] adj_rows [NODE_LIMIT];
   logic [CNT_WIDTH-1:0] state_count_now;
   closure_t             closure_q [$];

   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int cycles = 0;
   int errors = 0;
   int n_loads = 0;
   int n_queries = 0;
   int n_bad = 0;
   int n_cfg = 0;

   epsilon_closure_reachability_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_state_index  (req_state_index),
      .req_row_bits     (req_row_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_closure_mask (rsp_closure_mask),
      .rsp_bad_index    (rsp_bad_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic closure_t predict_closure(input logic [IDX_WIDTH-1:0] start);
      closure_t             r;
      int                   n;
      logic [ROW_WIDTH-1:0] keep;
      logic [ROW_WIDTH-1:0] found;
      logic [ROW_WIDTH-1:0] grown;
      n = state_count_now;
      if (n > NODE_LIMIT) n = NODE_LIMIT;
      if (n > ROW_WIDTH) n = ROW_WIDTH;
      r.mask = '0;
      r.bad  = 1'b1;
      if (int'(start) < n) begin
         keep = (n == ROW_WIDTH) ? '1 : ROW_WIDTH'((32'd1 << n) - 32'd1);
         found = '0;
         found[start] = 1'b1;
         for (int round = 0; round < ROW_WIDTH; round++) begin
            grown = found;
            for (int j = 0; j < n; j++) begin
               if (found[j]) grown = grown | (adj_rows[j] & keep);
            end
            found = grown;
         end
         r.mask = found;
         r.bad  = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [ROW_WIDTH-1:0] random_row(input int style, input int i);
      case (style)
         0: return ROW_WIDTH'($urandom);
         1: return ROW_WIDTH'(32'd1 << $urandom_range(0, ROW_WIDTH - 1));
         2: begin
            if ($urandom_range(0, 5) == 0)
               return ROW_WIDTH'((32'd1 << ((i + 1) % ROW_WIDTH)) |
                                 (32'd1 << $urandom_range(0, ROW_WIDTH - 1)));
            return ROW_WIDTH'(32'd1 << ((i + 1) % ROW_WIDTH));
         end
         3: return ROW_WIDTH'($urandom | $urandom);
         default: return ROW_WIDTH'($urandom & $urandom & $urandom);
      endcase
   endfunction

   // one beat on the request channel, predicted when accepted
   task automatic send_beat(input logic op, input logic [IDX_WIDTH-1:0] idx,
                            input logic [ROW_WIDTH-1:0] row);
      int       pause;
      closure_t want;
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid = 1'b0;
         pause = $urandom_range(1, 12);
         repeat (pause) @(negedge clock);
      end
      req_opcode      = op;
      req_state_index = idx;
      req_row_bits    = row;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) begin
         adj_rows[idx] = row;
         n_loads++;
      end else begin
         want = predict_closure(idx);
         closure_q.push_back(want);
         n_queries++;
         if (want.bad) n_bad++;
      end
      @(negedge clock);
   endtask

   task automatic load_row(input int idx, input logic [ROW_WIDTH-1:0] row);
      send_beat(OP_LOAD, IDX_WIDTH'(idx), row);
   endtask

   task automatic query(input int idx);
      send_beat(OP_QUERY, IDX_WIDTH'(idx), ROW_WIDTH'($urandom));
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (closure_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_state_count(input int value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = CNT_WIDTH'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      state_count_now = CNT_WIDTH'(value);
      n_cfg++;
   endtask

   task automatic note_mismatch(input string field, input logic [ROW_WIDTH-1:0] want,
                                input logic [ROW_WIDTH-1:0] got);
      errors++;
      if (errors <= MAX_SHOWN)
         $display("mismatch on %s at cycle %0d: expected %h, got %h", field, cycles, want, got);
   endtask

   always @(posedge clock) begin : check_results
      closure_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (closure_q.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("result beat at cycle %0d with nothing expected: mask %h bad %b",
                        cycles, rsp_closure_mask, rsp_bad_index);
         end else begin
            want = closure_q.pop_front();
            if (want.mask !== rsp_closure_mask)
               note_mismatch("closure_mask", want.mask, rsp_closure_mask);
            if (want.bad !== rsp_bad_index)
               note_mismatch("bad_index", ROW_WIDTH'(want.bad), ROW_WIDTH'(rsp_bad_index));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || stall_pct == 0) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
         stall_left <= $urandom_range(0, 11);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, closure_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_reset_rows();
      query(0);
      query(NODE_LIMIT - 1);
      drain();
   endtask

   task automatic test_edge_rows();
      load_row(0, 16'hFFFF);
      query(0);
      load_row(0, 16'h0000);
      load_row(15, 16'h8001);
      query(15);
      load_row(1, 16'h0004);
      load_row(2, 16'h0008);
      load_row(3, 16'h0002);
      query(1);
      load_row(4, 16'h0010);
      query(4);
      drain();
   endtask

   task automatic test_state_counts();
      set_state_count(0);
      query(0);
      set_state_count(1);
      query(0);
      query(1);
      set_state_count(31);
      query(15);
      set_state_count(17);
      query(15);
      set_state_count(3);
      load_row(2, 16'hFFF8);
      query(2);
      query(3);
      set_state_count(4);
      query(1);
      set_state_count(16);
   endtask

   task automatic test_random_graphs();
      int cnt;
      int live;
      int style;
      int nl;
      int nq;
      for (int p = 0; p < 22; p++) begin
         case ($urandom_range(0, 9))
            0: cnt = 16;
            1: cnt = $urandom_range(17, 31);
            2: cnt = 1;
            3: cnt = $urandom_range(0, 1);
            default: cnt = $urandom_range(2, 16);
         endcase
         set_state_count(cnt);
         live = (cnt > NODE_LIMIT) ? NODE_LIMIT : cnt;
         gap_pct   = $urandom_range(0, 2) * 15;
         stall_pct = $urandom_range(0, 2) * 15;
         style = $urandom_range(0, 4);
         nl = $urandom_range(4, 16);
         for (int k = 0; k < nl; k++) begin
            if (style == 2) load_row(k, random_row(style, k));
            else load_row($urandom_range(0, 15), random_row(style, 0));
         end
         nq = $urandom_range(35, 50);
         for (int k = 0; k < nq; k++) begin
            if ($urandom_range(0, 11) == 0)
               load_row($urandom_range(0, 15), random_row($urandom_range(0, 4), k));
            else if (live > 0 && $urandom_range(0, 99) < 85)
               query($urandom_range(0, live - 1));
            else
               query($urandom_range(0, 15));
            if ($urandom_range(0, 39) == 0) drain();
         end
      end
   endtask

   task automatic test_back_to_back();
      gap_pct   = 0;
      stall_pct = 0;
      set_state_count(16);
      for (int k = 0; k < 16; k++) load_row(k, random_row(2, k));
      for (int k = 0; k < 180; k++) begin
         if ($urandom_range(0, 7) == 0)
            load_row($urandom_range(0, 15), random_row($urandom_range(0, 4), k));
         else
            query($urandom_range(0, 15));
      end
   endtask

   initial begin
      for (int i = 0; i < NODE_LIMIT; i++) adj_rows[i] = '0;
      state_count_now = STATE_COUNT_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_rows();
      test_edge_rows();
      test_state_counts();
      test_random_graphs();
      test_back_to_back();
      drain();
      $display("covered %0d row loads and %0d closure queries (%0d out of range)",
               n_loads, n_queries, n_bad);
      $display("over %0d state count settings, %0d failures seen", n_cfg, errors);
      if (errors == 0 && closure_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
